// ===== rtl/core/dae_pkg.sv =====
// Package for the double-ended array store: widths, operation and status codes,
// configuration register indexes and reset values.
// No dependencies; used by the top level.
package dae_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int WORD_W      = 32;
    localparam int CAP_W       = 13;
    localparam int GROW_W      = 4;
    localparam int SHRINK_W    = 5;
    localparam int OP_W        = 3;
    localparam int IDX_W       = 8;
    localparam int ST_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 13;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);

    typedef enum logic [OP_W-1:0] {
        OP_GET        = 3'd0,
        OP_SET        = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PUSH_FRONT = 3'd4,
        OP_POP_FRONT  = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK      = 2'd2;

    localparam logic [CAP_W-1:0]    RESET_INIT_CAP = 13'd10;
    localparam logic [GROW_W-1:0]   RESET_GROW     = 4'd3;
    localparam logic [SHRINK_W-1:0] RESET_SHRINK   = 5'd5;
    localparam logic [CAP_W-1:0]    MIN_INIT_CAP   = 13'd2;
    localparam logic [GROW_W-1:0]   MIN_GROW       = 4'd3;

endpackage

// ===== rtl/core/dae_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module dae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/double_ended_array_store_top.sv =====
// Double-ended array store top level: deque control, grow/shrink policy, result registers.
// Depends on dae_pkg and dae_ram.
//
//   channel   signals                                     transaction
//   command   start, busy, operation, index, value        start && !busy at clk rise
//   result    done, status, read_value, element_count,    done high for one cycle
//             capacity
//   config    cfg_write, cfg_index, cfg_data              cfg_write at clk rise
//
// One operation per cycle; the result strobes on the cycle after acceptance.
// Get data comes from the word store's registered read, which lands with the result strobe.
// busy stays low: no clearing pass, the store is undefined until written.
// rst_n asynchronously clears pointer and count and resets capacity, offset and configuration.
// Results cannot be stalled by the receiver.
module double_ended_array_store_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dae_pkg::OP_W-1:0]            operation,
    input  logic [dae_pkg::IDX_W-1:0]           index,
    input  logic signed [dae_pkg::WORD_W-1:0]   value,
    output logic                                done,
    output logic [dae_pkg::ST_W-1:0]            status,
    output logic signed [dae_pkg::WORD_W-1:0]   read_value,
    output logic [dae_pkg::CNT_W-1:0]           element_count,
    output logic [dae_pkg::CAP_W-1:0]           capacity,
    input  logic                                cfg_write,
    input  logic [dae_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dae_pkg::CFG_W-1:0]           cfg_data
);

    logic [dae_pkg::CAP_W-1:0]    init_cap_reg;
    logic [dae_pkg::GROW_W-1:0]   grow_reg;
    logic [dae_pkg::SHRINK_W-1:0] shrink_reg;

    logic [dae_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [dae_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [dae_pkg::CAP_W-1:0]  cap_reg, cap_next;
    logic [dae_pkg::CAP_W-1:0]  off_reg, off_next;
    logic                       done_reg;
    dae_pkg::status_t           status_reg, status_next;
    logic                       get_ok_reg, get_ok_next;

    logic                       accept;
    logic [dae_pkg::CAP_W-1:0]  eff_init;
    logic [dae_pkg::GROW_W-1:0] eff_grow;
    logic [dae_pkg::CAP_W-1:0]  count_ext;
    logic [dae_pkg::CAP_W-1:0]  count_m1_ext;
    logic [dae_pkg::CAP_W-1:0]  grow_prod;
    logic [dae_pkg::CAP_W:0]    shrink_prod;
    logic [dae_pkg::CAP_W-1:0]  grow_cap;
    logic [dae_pkg::CAP_W-1:0]  grow_off;
    logic [dae_pkg::CAP_W-1:0]  shrink_cap;
    logic [dae_pkg::CAP_W-1:0]  front_off;
    logic                       back_end_hit;

    logic                        ram_we;
    logic [dae_pkg::ADDR_W-1:0]  ram_waddr;
    logic                        ram_re;
    logic [dae_pkg::ADDR_W-1:0]  ram_raddr;
    logic [dae_pkg::WORD_W-1:0]  ram_rdata;

    assign accept = start && !busy;
    assign busy   = 1'b0;

    assign eff_init = (init_cap_reg < dae_pkg::MIN_INIT_CAP) ? dae_pkg::MIN_INIT_CAP
                                                              : init_cap_reg;
    assign eff_grow = (grow_reg < dae_pkg::MIN_GROW) ? dae_pkg::MIN_GROW : grow_reg;

    assign count_ext    = dae_pkg::CAP_W'(count_reg);
    assign count_m1_ext = count_ext - 1'b1;
    assign grow_prod    = dae_pkg::CAP_W'(eff_grow) * count_ext;
    assign shrink_prod  = (dae_pkg::CAP_W + 1)'(shrink_reg) * (dae_pkg::CAP_W + 1)'(count_reg);

    assign grow_cap   = (count_reg == '0) ? eff_init : grow_prod;
    assign grow_off   = (grow_cap - count_ext) >> 1;
    assign shrink_cap = ({1'b0, cap_reg} > shrink_prod) ? grow_prod : cap_reg;
    assign front_off  = ((off_reg == '0) ? grow_off : off_reg) - 1'b1;
    assign back_end_hit = ({1'b0, off_reg} + {1'b0, count_ext}) == {1'b0, cap_reg};

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        cap_next    = cap_reg;
        off_next    = off_reg;
        status_next = dae_pkg::ST_OK;
        get_ok_next = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = head_reg + index;
        ram_raddr   = head_reg + index;
        if (accept)
        begin
            unique case (operation) inside
                dae_pkg::OP_GET, dae_pkg::OP_SET:
                begin
                    if (dae_pkg::CNT_W'(index) >= count_reg)
                    begin
                        status_next = dae_pkg::ST_BAD_INDEX;
                    end
                    else if (operation == dae_pkg::OP_GET)
                    begin
                        ram_re      = 1'b1;
                        get_ok_next = 1'b1;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                    end
                end
                dae_pkg::OP_PUSH_BACK:
                begin
                    if (count_reg == dae_pkg::FULL_COUNT)
                    begin
                        status_next = dae_pkg::ST_FULL;
                    end
                    else
                    begin
                        if (back_end_hit)
                        begin
                            cap_next = grow_cap;
                            off_next = grow_off;
                        end
                        ram_we     = 1'b1;
                        ram_waddr  = head_reg + count_reg[dae_pkg::ADDR_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                dae_pkg::OP_PUSH_FRONT:
                begin
                    if (count_reg == dae_pkg::FULL_COUNT)
                    begin
                        status_next = dae_pkg::ST_FULL;
                    end
                    else
                    begin
                        if (off_reg == '0)
                        begin
                            cap_next = grow_cap;
                        end
                        off_next   = front_off;
                        head_next  = head_reg - 1'b1;
                        ram_we     = 1'b1;
                        ram_waddr  = head_reg - 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                dae_pkg::OP_POP_BACK, dae_pkg::OP_POP_FRONT:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = dae_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cap_next   = shrink_cap;
                        off_next   = (shrink_cap - count_m1_ext) >> 1;
                        count_next = count_reg - 1'b1;
                        if (operation == dae_pkg::OP_POP_FRONT)
                        begin
                            head_next = head_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cap_reg <= dae_pkg::RESET_INIT_CAP;
            grow_reg     <= dae_pkg::RESET_GROW;
            shrink_reg   <= dae_pkg::RESET_SHRINK;
            head_reg     <= '0;
            count_reg    <= '0;
            cap_reg      <= dae_pkg::RESET_INIT_CAP;
            off_reg      <= dae_pkg::RESET_INIT_CAP >> 1;
            done_reg     <= 1'b0;
            status_reg   <= dae_pkg::ST_OK;
            get_ok_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    dae_pkg::CFG_INIT_CAP:    init_cap_reg <= cfg_data;
                    dae_pkg::CFG_GROW_FACTOR: grow_reg     <= cfg_data[dae_pkg::GROW_W-1:0];
                    dae_pkg::CFG_SHRINK:      shrink_reg   <= cfg_data[dae_pkg::SHRINK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            head_reg   <= head_next;
            count_reg  <= count_next;
            cap_reg    <= cap_next;
            off_reg    <= off_next;
            done_reg   <= accept;
            status_reg <= status_next;
            get_ok_reg <= get_ok_next;
        end
    end

    dae_ram #(
        .WIDTH(dae_pkg::WORD_W),
        .DEPTH(dae_pkg::MAX_ENTRIES)
    ) u_word_store (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(value),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign done          = done_reg;
    assign status        = status_reg;
    assign read_value    = get_ok_reg ? ram_rdata : '0;
    assign element_count = count_reg;
    assign capacity      = cap_reg;

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(accept))
        else $error("result strobe does not follow an accepted transaction");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dae_pkg::FULL_COUNT)
        else $error("element count above store depth");

    a_fail_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg != dae_pkg::ST_OK) |->
            ($stable(count_reg) && $stable(head_reg) && $stable(cap_reg)))
        else $error("failed transaction changed the state");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !get_ok_reg) |-> (read_value == '0))
        else $error("read value nonzero without a successful get");

    a_offset_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, off_reg} + {1'b0, count_ext}) <= {1'b0, cap_reg})
        else $error("virtual offset plus count exceeds capacity");

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for double_ended_array_store_top: directed and random deque operations,
// checked against a local predictor of the store, its pointers and grow/shrink policy.
// Depends on dae_pkg and the RTL of the block.
module testbench;

    localparam logic [dae_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [dae_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;

    typedef struct {
        dae_pkg::status_t                   st;
        logic signed [dae_pkg::WORD_W-1:0]  rd;
        logic [dae_pkg::CNT_W-1:0]          cnt;
        logic [dae_pkg::CAP_W-1:0]          cap;
    } deque_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [dae_pkg::OP_W-1:0]            operation = '0;
    logic [dae_pkg::IDX_W-1:0]           index = '0;
    logic signed [dae_pkg::WORD_W-1:0]   value = '0;
    logic                                done;
    logic [dae_pkg::ST_W-1:0]            status;
    logic signed [dae_pkg::WORD_W-1:0]   read_value;
    logic [dae_pkg::CNT_W-1:0]           element_count;
    logic [dae_pkg::CAP_W-1:0]           capacity;
    logic                                cfg_write = 1'b0;
    logic [dae_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [dae_pkg::CFG_W-1:0]           cfg_data = '0;

    // predicted deque state and configuration
    logic signed [dae_pkg::WORD_W-1:0]   deque_words [dae_pkg::MAX_ENTRIES];
    int unsigned                         deque_head;
    int unsigned                         deque_count;
    int unsigned                         virt_cap;
    int unsigned                         virt_off;
    int unsigned                         cfg_init_cap;
    int unsigned                         cfg_grow;
    int unsigned                         cfg_shrink;

    deque_result_t              pending_results[$];
    int                         failures = 0;
    int                         ops_sent = 0;
    int                         results_checked = 0;
    bit                         no_idle = 1'b0;

    double_ended_array_store_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .index         (index),
        .value         (value),
        .done          (done),
        .status        (status),
        .read_value    (read_value),
        .element_count (element_count),
        .capacity      (capacity),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int unsigned grow_mult();
        return (cfg_grow < dae_pkg::MIN_GROW) ? dae_pkg::MIN_GROW : cfg_grow;
    endfunction

    function automatic int unsigned init_cap_eff();
        return (cfg_init_cap < dae_pkg::MIN_INIT_CAP) ? dae_pkg::MIN_INIT_CAP : cfg_init_cap;
    endfunction

    function automatic void reset_model();
        cfg_init_cap = dae_pkg::RESET_INIT_CAP;
        cfg_grow     = dae_pkg::RESET_GROW;
        cfg_shrink   = dae_pkg::RESET_SHRINK;
        deque_head   = 0;
        deque_count  = 0;
        virt_cap     = init_cap_eff();
        virt_off     = virt_cap / 2;
    endfunction

    function automatic void regrow_virtual();
        virt_cap = (deque_count == 0) ? init_cap_eff() : grow_mult() * deque_count;
        virt_off = (virt_cap - deque_count) / 2;
    endfunction

    function automatic deque_result_t apply_deque_op(logic [dae_pkg::OP_W-1:0] op,
                                                     logic [dae_pkg::IDX_W-1:0] idx,
                                                     logic signed [dae_pkg::WORD_W-1:0] val);
        deque_result_t r;
        int unsigned   slot;
        int unsigned   old_cnt;
        r.st = dae_pkg::ST_OK;
        r.rd = '0;
        case (op)
            dae_pkg::OP_GET, dae_pkg::OP_SET:
            begin
                if (idx >= deque_count)
                    r.st = dae_pkg::ST_BAD_INDEX;
                else
                begin
                    slot = (deque_head + idx) % dae_pkg::MAX_ENTRIES;
                    if (op == dae_pkg::OP_GET)
                        r.rd = deque_words[slot];
                    else
                        deque_words[slot] = val;
                end
            end
            dae_pkg::OP_PUSH_BACK:
            begin
                if (deque_count >= dae_pkg::MAX_ENTRIES)
                    r.st = dae_pkg::ST_FULL;
                else
                begin
                    if (virt_off + deque_count == virt_cap)
                        regrow_virtual();
                    deque_words[(deque_head + deque_count) % dae_pkg::MAX_ENTRIES] = val;
                    deque_count++;
                end
            end
            dae_pkg::OP_PUSH_FRONT:
            begin
                if (deque_count >= dae_pkg::MAX_ENTRIES)
                    r.st = dae_pkg::ST_FULL;
                else
                begin
                    if (virt_off == 0)
                        regrow_virtual();
                    deque_head = (deque_head + dae_pkg::MAX_ENTRIES - 1) % dae_pkg::MAX_ENTRIES;
                    deque_words[deque_head] = val;
                    deque_count++;
                    virt_off--;
                end
            end
            dae_pkg::OP_POP_BACK, dae_pkg::OP_POP_FRONT:
            begin
                if (deque_count == 0)
                    r.st = dae_pkg::ST_EMPTY;
                else
                begin
                    if (op == dae_pkg::OP_POP_FRONT)
                        deque_head = (deque_head + 1) % dae_pkg::MAX_ENTRIES;
                    old_cnt = deque_count;
                    if (virt_cap > cfg_shrink * old_cnt)
                        virt_cap = grow_mult() * old_cnt;
                    deque_count = old_cnt - 1;
                    virt_off = (virt_cap - deque_count) / 2;
                end
            end
            default:
            begin
            end
        endcase
        r.cnt = deque_count[dae_pkg::CNT_W-1:0];
        r.cap = virt_cap[dae_pkg::CAP_W-1:0];
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic check_field(string what, logic [dae_pkg::WORD_W-1:0] want,
                               logic [dae_pkg::WORD_W-1:0] got);
        if (got !== want)
        begin
            failures++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        deque_result_t want;
        if (done)
        begin
            if (pending_results.size() == 0)
            begin
                failures++;
                $display("%0t: result with no transaction outstanding: expected none, actual %0h",
                         $time, status);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                results_checked++;
                check_field("status", dae_pkg::WORD_W'(want.st), dae_pkg::WORD_W'(status));
                check_field("read_value", want.rd, read_value);
                check_field("element_count", dae_pkg::WORD_W'(want.cnt),
                            dae_pkg::WORD_W'(element_count));
                check_field("capacity", dae_pkg::WORD_W'(want.cap), dae_pkg::WORD_W'(capacity));
            end
        end
    end

    task automatic send_op(logic [dae_pkg::OP_W-1:0] op, logic [dae_pkg::IDX_W-1:0] idx,
                           logic signed [dae_pkg::WORD_W-1:0] val);
        int unsigned gap;
        start     <= 1'b1;
        operation <= op;
        index     <= idx;
        value     <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.insert(pending_results.size(), apply_deque_op(op, idx, val));
        ops_sent++;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_results.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            failures++;
            $display("%0t: results missing: expected %0d more, actual 0",
                     $time, pending_results.size());
            pending_results.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(int unsigned icap, int unsigned gf, int unsigned sf);
        logic [dae_pkg::CFG_W-1:0] d_icap;
        logic [dae_pkg::CFG_W-1:0] d_gf;
        logic [dae_pkg::CFG_W-1:0] d_sf;
        d_icap = dae_pkg::CFG_W'(icap);
        d_gf   = dae_pkg::CFG_W'(gf);
        d_sf   = dae_pkg::CFG_W'(sf);
        cfg_write <= 1'b1;
        cfg_index <= dae_pkg::CFG_INIT_CAP;
        cfg_data  <= d_icap;
        @(posedge clk);
        cfg_index <= dae_pkg::CFG_GROW_FACTOR;
        cfg_data  <= d_gf;
        @(posedge clk);
        cfg_index <= dae_pkg::CFG_SHRINK;
        cfg_data  <= d_sf;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_init_cap = d_icap[dae_pkg::CAP_W-1:0];
        cfg_grow     = d_gf[dae_pkg::GROW_W-1:0];
        cfg_shrink   = d_sf[dae_pkg::SHRINK_W-1:0];
    endtask

    // push_pct steers the count up or down
    task automatic random_op(int unsigned push_pct);
        int unsigned                 roll;
        logic [dae_pkg::IDX_W-1:0]   idx;
        logic [dae_pkg::OP_W-1:0]    op;
        roll = $urandom_range(0, 99);
        if (deque_count != 0 && $urandom_range(0, 9) < 8)
            idx = dae_pkg::IDX_W'($urandom_range(0, deque_count - 1));
        else
            idx = dae_pkg::IDX_W'($urandom);
        if (roll < 3)
            op = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
        else if (roll < 19)
            op = dae_pkg::OP_GET;
        else if (roll < 31)
            op = dae_pkg::OP_SET;
        else if (roll < 31 + push_pct)
            op = $urandom_range(0, 1) ? dae_pkg::OP_PUSH_FRONT : dae_pkg::OP_PUSH_BACK;
        else
            op = $urandom_range(0, 1) ? dae_pkg::OP_POP_FRONT : dae_pkg::OP_POP_BACK;
        send_op(op, idx, $urandom);
    endtask

    task automatic test_empty_store();
        send_op(dae_pkg::OP_GET, 8'd0, 32'sd0);
        send_op(dae_pkg::OP_SET, 8'd255, 32'sd1);
        send_op(dae_pkg::OP_POP_BACK, 8'd0, 32'sd0);
        send_op(dae_pkg::OP_POP_FRONT, 8'd0, 32'sd0);
        send_op(OP_RSVD_6, 8'd255, -32'sd1);
        send_op(OP_RSVD_7, 8'd0, 32'sd0);
    endtask

    task automatic test_edge_values();
        send_op(dae_pkg::OP_PUSH_BACK, 8'd0, 32'sh7FFF_FFFF);
        send_op(dae_pkg::OP_PUSH_BACK, 8'd0, 32'sh8000_0000);
        send_op(dae_pkg::OP_PUSH_FRONT, 8'd0, 32'sd0);
        send_op(dae_pkg::OP_PUSH_FRONT, 8'd0, -32'sd1);
        for (int i = 0; i < 4; i++)
            send_op(dae_pkg::OP_GET, dae_pkg::IDX_W'(i), 32'sd0);
        send_op(dae_pkg::OP_GET, 8'd4, 32'sd0);
        send_op(dae_pkg::OP_GET, 8'd255, 32'sd0);
        send_op(dae_pkg::OP_SET, 8'd1, 32'sh5555_5555);
        send_op(dae_pkg::OP_SET, 8'd2, 32'shAAAA_AAAA);
        send_op(dae_pkg::OP_SET, 8'd4, 32'sd7);
        send_op(dae_pkg::OP_GET, 8'd1, 32'sd0);
        send_op(dae_pkg::OP_GET, 8'd2, 32'sd0);
        send_op(dae_pkg::OP_POP_FRONT, 8'd0, 32'sd0);
        send_op(dae_pkg::OP_POP_BACK, 8'd0, 32'sd0);
        send_op(dae_pkg::OP_GET, 8'd0, 32'sd0);
        send_op(dae_pkg::OP_POP_BACK, 8'd0, 32'sd0);
        send_op(dae_pkg::OP_POP_FRONT, 8'd0, 32'sd0);
        send_op(dae_pkg::OP_POP_FRONT, 8'd0, 32'sd0);
    endtask

    task automatic test_fill_and_drain();
        no_idle = 1'b1;
        while (deque_count < dae_pkg::MAX_ENTRIES)
            send_op($urandom_range(0, 1) ? dae_pkg::OP_PUSH_FRONT : dae_pkg::OP_PUSH_BACK,
                    dae_pkg::IDX_W'($urandom), $urandom);
        no_idle = 1'b0;
        send_op(dae_pkg::OP_PUSH_BACK, 8'd0, $urandom);
        send_op(dae_pkg::OP_PUSH_FRONT, 8'd0, $urandom);
        send_op(dae_pkg::OP_GET, 8'd255, 32'sd0);
        send_op(dae_pkg::OP_SET, 8'd255, $urandom);
        send_op(dae_pkg::OP_GET, 8'd255, 32'sd0);
        send_op(dae_pkg::OP_GET, 8'd0, 32'sd0);
        while (deque_count != 0)
            send_op($urandom_range(0, 1) ? dae_pkg::OP_POP_FRONT : dae_pkg::OP_POP_BACK,
                    8'd0, 32'sd0);
        send_op(dae_pkg::OP_POP_BACK, 8'd0, 32'sd0);
    endtask

    task automatic test_config_sweep();
        int unsigned icap_set [6] = '{0, 1, 2, 4096, 8191, 10};
        int unsigned grow_set [6] = '{0, 15, 3, 8, 15, 3};
        int unsigned shr_set  [6] = '{0, 31, 2, 16, 1, 5};
        for (int s = 0; s < 6; s++)
        begin
            wait_idle();
            set_config(icap_set[s], grow_set[s], shr_set[s]);
            no_idle = (s % 2 == 1);
            repeat (25) random_op(55);
            no_idle = 1'b0;
            repeat (25) random_op(20);
        end
    endtask

    task automatic test_random_mix();
        int unsigned push_pct;
        for (int chunk = 0; chunk < 10; chunk++)
        begin
            push_pct = $urandom_range(20, 60);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (20) random_op(push_pct);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        reset_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_store();
        test_edge_values();
        test_fill_and_drain();
        test_config_sweep();
        test_random_mix();
        wait_idle();
        $display("Ran %0d transactions, %0d results checked: empty/full/index errors,",
                 ops_sent, results_checked);
        $display("both ends, grow and shrink across six register settings.");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
